/* hw/rtl/damped_sine_shake_offset_defines.svh */
// Assertion macros shared by the damped shake offset design.
`ifndef DAMPED_SINE_SHAKE_OFFSET_DEFINES_SVH
`define DAMPED_SINE_SHAKE_OFFSET_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define DSSO_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define DSSO_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `DSSO_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

/* hw/rtl/dsso_pkg.sv */
package dsso_pkg;

  localparam int unsigned TICK_BITS     = 12;
  localparam int unsigned TICK_MAX      = (1 << TICK_BITS) - 1;
  localparam int unsigned START_TICKS_W = 12;
  localparam int unsigned CAM_W         = 32;
  localparam int unsigned OFFSET_W      = 28;
  localparam int unsigned POS_W         = 4;
  localparam int unsigned SINE_W        = 11;
  localparam int unsigned EXP_W         = 11;
  localparam int unsigned EXP_IDX_W     = 6;
  localparam int unsigned QUO_W         = EXP_IDX_W + 1;
  localparam int unsigned DIV_STEPS     = QUO_W;
  localparam int unsigned AMP_SHIFT     = 5;
  localparam int unsigned PROD_W        = SINE_W + EXP_W + 1;
  localparam int unsigned CNT_W         = $clog2(TICK_BITS + 1);

  localparam logic [POS_W-1:0]     SINE_LAST   = 4'd9;
  localparam logic [EXP_IDX_W-1:0] EXP_IDX_MAX = 6'd63;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_START = 1'b1;

  typedef struct packed {
    logic                 start;
    logic [TICK_BITS-1:0] rem;
    logic [TICK_BITS-1:0] total;
    logic [POS_W-1:0]     pos;
  } dsso_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [OFFSET_W-1:0] offset;
  } dsso_resp_t;

  function automatic logic signed [SINE_W-1:0] sine_rom(input logic [POS_W-1:0] idx);
    logic signed [SINE_W-1:0] val;
    case (idx)
      4'd0:    val = -11'sd601;
      4'd1:    val = -11'sd973;
      4'd2:    val = -11'sd973;
      4'd3:    val = -11'sd601;
      4'd5:    val = 11'sd602;
      4'd6:    val = 11'sd974;
      4'd7:    val = 11'sd974;
      4'd8:    val = 11'sd602;
      default: val = 11'sd0;
    endcase
    return val;
  endfunction

  function automatic logic [EXP_W-1:0] exp_rom(input logic [EXP_IDX_W-1:0] idx);
    logic [EXP_W-1:0] val;
    case (idx)
      6'd0:  val = 11'd1024; 6'd1:  val = 11'd945;  6'd2:  val = 11'd873;
      6'd3:  val = 11'd807;  6'd4:  val = 11'd745;  6'd5:  val = 11'd688;
      6'd6:  val = 11'd636;  6'd7:  val = 11'd587;  6'd8:  val = 11'd542;
      6'd9:  val = 11'd501;  6'd10: val = 11'd463;  6'd11: val = 11'd427;
      6'd12: val = 11'd395;  6'd13: val = 11'd364;  6'd14: val = 11'd337;
      6'd15: val = 11'd311;  6'd16: val = 11'd287;  6'd17: val = 11'd265;
      6'd18: val = 11'd245;  6'd19: val = 11'd226;  6'd20: val = 11'd209;
      6'd21: val = 11'd193;  6'd22: val = 11'd178;  6'd23: val = 11'd165;
      6'd24: val = 11'd152;  6'd25: val = 11'd140;  6'd26: val = 11'd130;
      6'd27: val = 11'd120;  6'd28: val = 11'd110;  6'd29: val = 11'd102;
      6'd30: val = 11'd94;   6'd31: val = 11'd87;   6'd32: val = 11'd80;
      6'd33: val = 11'd74;   6'd34: val = 11'd68;   6'd35: val = 11'd63;
      6'd36: val = 11'd58;   6'd37: val = 11'd54;   6'd38: val = 11'd50;
      6'd39: val = 11'd46;   6'd40: val = 11'd42;   6'd41: val = 11'd39;
      6'd42: val = 11'd36;   6'd43: val = 11'd33;   6'd44: val = 11'd31;
      6'd45: val = 11'd28;   6'd46: val = 11'd26;   6'd47: val = 11'd24;
      6'd48: val = 11'd22;   6'd49: val = 11'd20;   6'd50: val = 11'd19;
      6'd51: val = 11'd17;   6'd52: val = 11'd16;   6'd53: val = 11'd15;
      6'd54: val = 11'd14;   6'd55: val = 11'd13;   6'd56: val = 11'd12;
      6'd57: val = 11'd11;   6'd58: val = 11'd10;   6'd59: val = 11'd9;
      6'd60: val = 11'd8;    6'd61: val = 11'd8;    6'd62: val = 11'd7;
      default: val = 11'd6;
    endcase
    return val;
  endfunction

  function automatic logic [TICK_BITS-1:0] sat_ticks(input logic [START_TICKS_W-1:0] t);
    if (32'(t) > 32'(TICK_MAX)) begin
      return TICK_BITS'(TICK_MAX);
    end
    return TICK_BITS'(t);
  endfunction

endpackage

/* hw/rtl/dsso_iter_unit.sv */
module dsso_iter_unit import dsso_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dsso_req_t  req_i,
  output dsso_resp_t resp_o
);

  typedef enum logic [1:0] {
    U_IDLE,
    U_DIV,
    U_AMP,
    U_MUL
  } unit_state_e;

  unit_state_e          state_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 done_q;
  logic [TICK_BITS-1:0] total_q;
  logic [POS_W-1:0]     pos_q;
  logic [TICK_BITS:0]   part_q;
  logic [QUO_W-1:0]     quo_q;
  logic [OFFSET_W-1:0]  mcand_q;
  logic [TICK_BITS-1:0] mplier_q;
  logic [OFFSET_W-1:0]  acc_q;

  logic [OFFSET_W-1:0]  add_a;
  logic [OFFSET_W-1:0]  add_b;
  logic                 add_sub;
  logic [OFFSET_W:0]    add_sum;
  logic                 div_ge;
  logic [TICK_BITS-1:0] div_rest;
  logic [EXP_IDX_W-1:0] exp_idx;
  logic signed [PROD_W-1:0] amp_prod;

  // One adder serves both the restoring divide and the shift-add multiply.
  always_comb begin
    if (state_q == U_DIV) begin
      add_a   = OFFSET_W'(part_q);
      add_b   = OFFSET_W'(total_q);
      add_sub = 1'b1;
    end else begin
      add_a   = acc_q;
      add_b   = mplier_q[0] ? mcand_q : '0;
      add_sub = 1'b0;
    end
    add_sum  = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (OFFSET_W + 1)'(add_sub);
    div_ge   = add_sum[OFFSET_W];
    div_rest = div_ge ? add_sum[TICK_BITS-1:0] : part_q[TICK_BITS-1:0];
  end

  always_comb begin
    if (quo_q[QUO_W-1]) begin
      exp_idx = '0;
    end else if (quo_q[EXP_IDX_W-1:0] == '0) begin
      exp_idx = EXP_IDX_MAX;
    end else begin
      exp_idx = EXP_IDX_W'(0) - quo_q[EXP_IDX_W-1:0];
    end
    amp_prod = PROD_W'(sine_rom(pos_q)) * $signed(PROD_W'(exp_rom(exp_idx)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= U_IDLE;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      total_q  <= '0;
      pos_q    <= '0;
      part_q   <= '0;
      quo_q    <= '0;
      mcand_q  <= '0;
      mplier_q <= '0;
      acc_q    <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        U_IDLE: begin
          if (req_i.start) begin
            total_q <= req_i.total;
            pos_q   <= req_i.pos;
            part_q  <= {1'b0, req_i.rem};
            quo_q   <= '0;
            cnt_q   <= '0;
            state_q <= U_DIV;
          end
        end
        U_DIV: begin
          part_q <= {div_rest, 1'b0};
          quo_q  <= {quo_q[QUO_W-2:0], div_ge};
          if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
            state_q <= U_AMP;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        U_AMP: begin
          mcand_q  <= OFFSET_W'(amp_prod >>> AMP_SHIFT);
          mplier_q <= total_q;
          acc_q    <= '0;
          cnt_q    <= '0;
          state_q  <= U_MUL;
        end
        U_MUL: begin
          acc_q    <= add_sum[OFFSET_W-1:0];
          mcand_q  <= {mcand_q[OFFSET_W-2:0], 1'b0};
          mplier_q <= mplier_q >> 1;
          if (cnt_q == CNT_W'(TICK_BITS - 1)) begin
            done_q  <= 1'b1;
            state_q <= U_IDLE;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        default: state_q <= U_IDLE;
      endcase
    end
  end

  assign resp_o.done   = done_q;
  assign resp_o.offset = $signed(acc_q);

endmodule

/* hw/rtl/damped_sine_shake_offset.sv */
// Channel   Direction  Handshake                Payload
// input     in         in_valid_i / in_stall_o  action_i, start_ticks_i, camera_y_i
// output    out        out_valid_o / out_stall_i camera_y_out_o, offset_o, applied_o
//
// A start, an idle tick or a tick that ends the shake goes via S_OUT to the output.
// A tick that forms a new offset also passes S_START and S_CALC, for 7 divide
// steps and TICK_BITS multiply steps, all through the one adder in dsso_iter_unit.
// Reset clears the shake state, so the block starts idle with a zero offset.
// The input is stalled while a transaction is being worked on, and a finished result
// waits in the output register for as long as the output is stalled.

`include "damped_sine_shake_offset_defines.svh"

module damped_sine_shake_offset import dsso_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       action_i,
  input  logic [START_TICKS_W-1:0]   start_ticks_i,
  input  logic signed [CAM_W-1:0]    camera_y_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [CAM_W-1:0]    camera_y_out_o,
  output logic signed [OFFSET_W-1:0] offset_o,
  output logic                       applied_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_CALC,
    S_OUT
  } state_e;

  state_e                     state_q;
  logic                       shaking_q;
  logic [TICK_BITS-1:0]       rem_q;
  logic [TICK_BITS-1:0]       total_q;
  logic [POS_W-1:0]           pos_q;
  logic signed [OFFSET_W-1:0] cur_q;
  logic signed [CAM_W-1:0]    cam_q;
  logic                       applied_q;
  logic                       out_valid_q;
  logic signed [CAM_W-1:0]    cam_out_q;
  logic signed [OFFSET_W-1:0] offset_out_q;
  logic                       applied_out_q;

  logic [TICK_BITS-1:0] rem_dec;
  logic [TICK_BITS-1:0] start_sat;
  logic [POS_W-1:0]     pos_next;
  logic                 take_off;
  logic                 go_calc;
  dsso_req_t            unit_req;
  dsso_resp_t           unit_resp;

  assign rem_dec   = (rem_q != '0) ? rem_q - TICK_BITS'(1) : rem_q;
  assign start_sat = sat_ticks(start_ticks_i);
  assign pos_next  = (pos_q == POS_W'(1)) ? SINE_LAST : pos_q - POS_W'(1);

  assign take_off = (action_i == ACT_START) ? (start_ticks_i != '0 && shaking_q)
                                            : (shaking_q && cur_q != '0);
  assign go_calc  = (action_i == ACT_TICK) && shaking_q && (cur_q == '0 || rem_dec != '0);

  assign unit_req.start = (state_q == S_START);
  assign unit_req.rem   = rem_q;
  assign unit_req.total = total_q;
  assign unit_req.pos   = pos_q;

  dsso_iter_unit u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (unit_req),
    .resp_o (unit_resp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      shaking_q     <= 1'b0;
      rem_q         <= '0;
      total_q       <= '0;
      pos_q         <= '0;
      cur_q         <= '0;
      cam_q         <= '0;
      applied_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      cam_out_q     <= '0;
      offset_out_q  <= '0;
      applied_out_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cam_q     <= take_off ? camera_y_i - CAM_W'(cur_q) : camera_y_i;
            applied_q <= 1'b0;
            state_q   <= go_calc ? S_START : S_OUT;
            if (take_off) begin
              cur_q <= '0;
            end
            if (action_i == ACT_START) begin
              if (start_ticks_i != '0) begin
                shaking_q <= 1'b1;
                rem_q     <= start_sat;
                total_q   <= start_sat;
                pos_q     <= SINE_LAST;
              end
            end else if (shaking_q && cur_q != '0) begin
              rem_q <= rem_dec;
              if (rem_dec == '0) begin
                shaking_q <= 1'b0;
                pos_q     <= '0;
              end
            end
          end
        end
        S_START: state_q <= S_CALC;
        S_CALC: begin
          if (unit_resp.done) begin
            cur_q     <= unit_resp.offset;
            cam_q     <= cam_q + CAM_W'($signed(unit_resp.offset));
            pos_q     <= pos_next;
            applied_q <= 1'b1;
            state_q   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            cam_out_q     <= cam_q;
            offset_out_q  <= cur_q;
            applied_out_q <= applied_q;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign camera_y_out_o = cam_out_q;
  assign offset_o       = offset_out_q;
  assign applied_o      = applied_out_q;

  `DSSO_ASSERT_NEVER(a_idle_no_offset, clk_i, rst_ni,
                     !shaking_q && cur_q != '0, "offset held while not shaking")
  `DSSO_ASSERT_NEVER(a_shake_state, clk_i, rst_ni,
                     shaking_q && (rem_q == '0 || pos_q == '0 || pos_q > SINE_LAST),
                     "bad shake count or sine position")
  `DSSO_ASSERT(a_done_in_calc, clk_i, rst_ni,
               unit_resp.done |-> state_q == S_CALC, "unit finished outside calculation")
  `DSSO_ASSERT(a_accept_busy, clk_i, rst_ni,
               (state_q == S_IDLE && in_valid_i) |=> state_q != S_IDLE,
               "accepted transaction not taken up")

endmodule
